// ===== rtl/core/qmm_pkg.sv =====
package qmm_pkg;

  localparam int THR_W    = 15;
  localparam int CMD_W    = 16;
  localparam int ANG_W    = 17;
  localparam int MOT_W    = 11;
  localparam int BIAS_W   = 15;
  localparam int TILT_W   = 16;
  localparam int FRAC_W   = 4;
  localparam int AUTH_W   = 16;
  localparam int MIX_FRAC = 18;
  localparam int CMD_SH   = 14;
  localparam int MIX_W    = 36;

  localparam int DEN_W          = THR_W;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = AUTH_W / BITS_PER_STAGE;

  typedef enum logic [2:0] {
    REG_MIN  = 3'd0,
    REG_MAX  = 3'd1,
    REG_FULL = 3'd2,
    REG_BIAS = 3'd3,
    REG_TILT = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    AUTH_ZERO,
    AUTH_FULL,
    AUTH_DIV
  } auth_sel_t;

  typedef struct packed {
    logic                    armed;
    logic                    trip;
    auth_sel_t               sel;
    logic [THR_W-1:0]        thr;
    logic signed [CMD_W-1:0] pc;
    logic signed [CMD_W-1:0] rc;
    logic signed [CMD_W-1:0] yc;
  } ctl_t;

  typedef struct packed {
    logic                    armed;
    logic                    trip;
    logic signed [CMD_W-1:0] p;
    logic signed [CMD_W-1:0] r;
    logic signed [CMD_W-1:0] y;
  } res_t;

endpackage

// ===== rtl/core/qmm_divider.sv =====
module qmm_divider (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qmm_pkg::DEN_W-1:0]   num,
  input  logic [qmm_pkg::DEN_W-1:0]   den,
  output logic [qmm_pkg::AUTH_W-1:0]  quo
);
  import qmm_pkg::*;

  // restoring division of num * 2^AUTH_W by den, num < den
  logic [DEN_W-1:0]  rem   [DIV_STAGES];
  logic [AUTH_W-1:0] quo_r [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [DEN_W-1:0]  r_in;
    logic [AUTH_W-1:0] q_in;
    logic [DEN_W-1:0]  rem_next;
    logic [AUTH_W-1:0] quo_next;

    if (g == 0) begin : g_first
      assign r_in = num;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[g-1];
      assign q_in = quo_r[g-1];
    end

    always_comb begin
      logic [DEN_W:0] t;
      rem_next = r_in;
      quo_next = q_in;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        t = {rem_next, 1'b0};
        if (t >= {1'b0, den}) begin
          t        = t - {1'b0, den};
          quo_next = {quo_next[AUTH_W-2:0], 1'b1};
        end else begin
          quo_next = {quo_next[AUTH_W-2:0], 1'b0};
        end
        rem_next = t[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]   <= rem_next;
        quo_r[g] <= quo_next;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

// ===== rtl/core/quad_motor_mixer_desaturate.sv =====
// Quadcopter X-layout motor mixer with collective desaturation.
//
// Input channel: in_valid / in_stall carry one control tick (armed, throttle,
// three rate commands, pitch and roll angles). Output channel: out_valid /
// out_stall carry one result per tick: four motor commands, disarm_request
// and the three authority-scaled commands.
// Configuration goes through the APB-style port, registers at byte address
// 4*index; pready is tied high and reads return the register.
//
// Throughput: one transfer per cycle while the receiver does not stall. The
// pipeline has 16 register stages: input register, classification, 8-stage
// authority divider (2 quotient bits a stage), then scaling products, scaled
// commands, mixing, limit search, offset and clamp.
//
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall is raised in the same cycle; nothing is dropped or repeated.
module quad_motor_mixer_desaturate (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               armed,
  input  logic [qmm_pkg::THR_W-1:0]          throttle,
  input  logic signed [qmm_pkg::CMD_W-1:0]   pitch_rate_cmd,
  input  logic signed [qmm_pkg::CMD_W-1:0]   roll_rate_cmd,
  input  logic signed [qmm_pkg::CMD_W-1:0]   yaw_rate_cmd,
  input  logic signed [qmm_pkg::ANG_W-1:0]   pitch_angle,
  input  logic signed [qmm_pkg::ANG_W-1:0]   roll_angle,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [qmm_pkg::MOT_W-1:0]          motor_front_a,
  output logic [qmm_pkg::MOT_W-1:0]          motor_rear_a,
  output logic [qmm_pkg::MOT_W-1:0]          motor_front_b,
  output logic [qmm_pkg::MOT_W-1:0]          motor_rear_b,
  output logic                               disarm_request,
  output logic signed [qmm_pkg::CMD_W-1:0]   pitch_scaled,
  output logic signed [qmm_pkg::CMD_W-1:0]   roll_scaled,
  output logic signed [qmm_pkg::CMD_W-1:0]   yaw_scaled
);
  import qmm_pkg::*;

  // configuration
  logic [MOT_W-1:0]  cfg_min;
  logic [MOT_W-1:0]  cfg_max;
  logic [MOT_W-1:0]  cfg_full;
  logic [BIAS_W-1:0] cfg_bias;
  logic [TILT_W-1:0] cfg_tilt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_min  <= MOT_W'(48);
      cfg_max  <= MOT_W'(2047);
      cfg_full <= MOT_W'(1000);
      cfg_bias <= BIAS_W'(16384);
      cfg_tilt <= TILT_W'(15360);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_MIN:  cfg_min  <= pwdata[MOT_W-1:0];
        REG_MAX:  cfg_max  <= pwdata[MOT_W-1:0];
        REG_FULL: cfg_full <= pwdata[MOT_W-1:0];
        REG_BIAS: cfg_bias <= pwdata[BIAS_W-1:0];
        REG_TILT: cfg_tilt <= pwdata[TILT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_MIN:  prdata = 32'(cfg_min);
      REG_MAX:  prdata = 32'(cfg_max);
      REG_FULL: prdata = 32'(cfg_full);
      REG_BIAS: prdata = 32'(cfg_bias);
      REG_TILT: prdata = 32'(cfg_tilt);
      default:  prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // pipeline advance
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // stage 1: input register
  logic                    v1;
  logic                    s1_armed;
  logic [THR_W-1:0]        s1_thr;
  logic signed [CMD_W-1:0] s1_pc, s1_rc, s1_yc;
  logic [ANG_W-1:0]        s1_pa, s1_ra;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_armed <= armed;
      s1_thr   <= throttle;
      s1_pc    <= pitch_rate_cmd;
      s1_rc    <= roll_rate_cmd;
      s1_yc    <= yaw_rate_cmd;
      s1_pa    <= pitch_angle;
      s1_ra    <= roll_angle;
    end
  end

  // stage 2: tilt test and authority classification
  logic [ANG_W:0]        pa_mag, ra_mag;
  logic signed [THR_W+1:0] num, den;
  ctl_t                  ctl2_next;

  always_comb begin
    pa_mag = s1_pa[ANG_W-1] ? (~{1'b1, s1_pa} + 1'b1) : {1'b0, s1_pa};
    ra_mag = s1_ra[ANG_W-1] ? (~{1'b1, s1_ra} + 1'b1) : {1'b0, s1_ra};
    num = $signed({2'b00, s1_thr}) - $signed({2'b00, cfg_min, {FRAC_W{1'b0}}});
    den = $signed({2'b00, cfg_full, {FRAC_W{1'b0}}})
        - $signed({2'b00, cfg_min, {FRAC_W{1'b0}}});
    ctl2_next.armed = s1_armed;
    ctl2_next.trip  = (pa_mag > (ANG_W+1)'(cfg_tilt)) || (ra_mag > (ANG_W+1)'(cfg_tilt));
    ctl2_next.thr   = s1_thr;
    ctl2_next.pc    = s1_pc;
    ctl2_next.rc    = s1_rc;
    ctl2_next.yc    = s1_yc;
    if (num <= 0) begin
      ctl2_next.sel = AUTH_ZERO;
    end else if (den <= 0 || num >= den) begin
      ctl2_next.sel = AUTH_FULL;
    end else begin
      ctl2_next.sel = AUTH_DIV;
    end
  end

  logic             v2;
  ctl_t             s2_ctl;
  logic [DEN_W-1:0] s2_num, s2_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl <= ctl2_next;
      s2_num <= num[DEN_W-1:0];
      s2_den <= den[DEN_W-1:0];
    end
  end

  // divider with matching control line
  logic [AUTH_W-1:0] quo;

  qmm_divider u_div (
    .clk (clk),
    .en  (en),
    .num (s2_num),
    .den (s2_den),
    .quo (quo)
  );

  logic dv   [DIV_STAGES];
  ctl_t dctl [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) dv[i] <= 1'b0;
    end else if (en) begin
      dv[0] <= v2;
      for (int i = 1; i < DIV_STAGES; i++) dv[i] <= dv[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dctl[0] <= s2_ctl;
      for (int i = 1; i < DIV_STAGES; i++) dctl[i] <= dctl[i-1];
    end
  end

  // stage 3: authority scaling products
  ctl_t                c3;
  logic [AUTH_W:0]     auth;
  logic [CMD_W:0]      pm, rm, ym;

  assign c3 = dctl[DIV_STAGES-1];

  always_comb begin
    case (c3.sel)
      AUTH_ZERO: auth = '0;
      AUTH_FULL: auth = {1'b1, {AUTH_W{1'b0}}};
      default:   auth = {1'b0, quo};
    endcase
    pm = c3.pc[CMD_W-1] ? (~{1'b1, c3.pc} + 1'b1) : {1'b0, c3.pc};
    rm = c3.rc[CMD_W-1] ? (~{1'b1, c3.rc} + 1'b1) : {1'b0, c3.rc};
    ym = c3.yc[CMD_W-1] ? (~{1'b1, c3.yc} + 1'b1) : {1'b0, c3.yc};
  end

  logic                      v3;
  logic                      s3_armed, s3_trip;
  logic                      s3_pn, s3_rn, s3_yn;
  logic [CMD_W+AUTH_W+1:0]   s3_pp, s3_rp, s3_yp;
  logic [THR_W+BIAS_W-1:0]   s3_tf;
  logic [THR_W-1:0]          s3_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= dv[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_armed <= c3.armed;
      s3_trip  <= c3.trip;
      s3_pn    <= c3.pc[CMD_W-1];
      s3_rn    <= c3.rc[CMD_W-1];
      s3_yn    <= c3.yc[CMD_W-1];
      s3_pp    <= pm * auth;
      s3_rp    <= rm * auth;
      s3_yp    <= ym * auth;
      s3_tf    <= c3.thr * cfg_bias;
      s3_thr   <= c3.thr;
    end
  end

  // stage 4: scaled commands, truncated toward zero
  logic [CMD_W:0] pq, rq, yq;
  res_t           r4_next;

  always_comb begin
    pq = s3_pp[CMD_W+AUTH_W:AUTH_W];
    rq = s3_rp[CMD_W+AUTH_W:AUTH_W];
    yq = s3_yp[CMD_W+AUTH_W:AUTH_W];
    r4_next.armed = s3_armed;
    r4_next.trip  = s3_trip;
    r4_next.p     = s3_pn ? CMD_W'(-pq) : CMD_W'(pq);
    r4_next.r     = s3_rn ? CMD_W'(-rq) : CMD_W'(rq);
    r4_next.y     = s3_yn ? CMD_W'(-yq) : CMD_W'(yq);
  end

  logic                    v4;
  res_t                    s4_res;
  logic [THR_W+BIAS_W-1:0] s4_tf;
  logic [THR_W-1:0]        s4_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_res <= r4_next;
      s4_tf  <= s3_tf;
      s4_thr <= s3_thr;
    end
  end

  // stage 5: X mix in Q.18
  logic signed [MIX_W-1:0] tfe, tre, pe, re, ye;
  logic signed [MIX_W-1:0] m5_next [4];

  always_comb begin
    tfe = $signed(MIX_W'(s4_tf));
    tre = $signed(MIX_W'({s4_thr, {CMD_SH{1'b0}}}));
    pe  = MIX_W'(s4_res.p);
    re  = MIX_W'(s4_res.r);
    ye  = MIX_W'(s4_res.y);
    m5_next[0] = tfe + ((pe - re - ye) <<< CMD_SH);
    m5_next[1] = tre + ((re - pe + ye) <<< CMD_SH) - ((re + re) <<< CMD_SH);
    m5_next[2] = tfe + ((pe + re + ye) <<< CMD_SH);
    m5_next[3] = tre + ((re - pe - ye) <<< CMD_SH);
  end

  logic                    v5;
  res_t                    s5_res;
  logic signed [MIX_W-1:0] s5_m [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_res <= s4_res;
      for (int i = 0; i < 4; i++) s5_m[i] <= m5_next[i];
    end
  end

  // stage 6: highest and lowest motor
  logic signed [MIX_W-1:0] hi01, hi23, lo01, lo23;

  always_comb begin
    hi01 = (s5_m[0] > s5_m[1]) ? s5_m[0] : s5_m[1];
    hi23 = (s5_m[2] > s5_m[3]) ? s5_m[2] : s5_m[3];
    lo01 = (s5_m[0] < s5_m[1]) ? s5_m[0] : s5_m[1];
    lo23 = (s5_m[2] < s5_m[3]) ? s5_m[2] : s5_m[3];
  end

  logic                    v6;
  res_t                    s6_res;
  logic signed [MIX_W-1:0] s6_m [4];
  logic signed [MIX_W-1:0] s6_hi, s6_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_res <= s5_res;
      for (int i = 0; i < 4; i++) s6_m[i] <= s5_m[i];
      s6_hi <= (hi01 > hi23) ? hi01 : hi23;
      s6_lo <= (lo01 < lo23) ? lo01 : lo23;
    end
  end

  // stage 7: collective offset, top limit first
  logic signed [MIX_W-1:0] lim_hi, lim_lo, up, dn, off_next;

  always_comb begin
    lim_hi = $signed(MIX_W'({cfg_max, {MIX_FRAC{1'b0}}}));
    lim_lo = $signed(MIX_W'({cfg_min, {MIX_FRAC{1'b0}}}));
    dn     = lim_hi - s6_hi;
    up     = lim_lo - s6_lo;
    if (s6_hi > lim_hi) begin
      off_next = dn;
    end else if (s6_lo < lim_lo) begin
      off_next = (up < dn) ? up : dn;
    end else begin
      off_next = '0;
    end
  end

  logic                    v7;
  res_t                    s7_res;
  logic signed [MIX_W-1:0] s7_m [4];
  logic signed [MIX_W-1:0] s7_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_res <= s6_res;
      for (int i = 0; i < 4; i++) s7_m[i] <= s6_m[i];
      s7_off <= off_next;
    end
  end

  // stage 8: clamp, truncate, clamp to min..max; zero unless armed and not tripped
  logic signed [MIX_W-1:0] vsum [4];
  logic [MOT_W-1:0]        mot  [4];
  logic                    live;

  always_comb begin
    live = s7_res.armed && !s7_res.trip;
    for (int i = 0; i < 4; i++) begin
      vsum[i] = s7_m[i] + s7_off;
      if (vsum[i] < 0) vsum[i] = '0;
      if (vsum[i] > lim_hi) vsum[i] = lim_hi;
      mot[i] = vsum[i][MOT_W+MIX_FRAC-1:MIX_FRAC];
      if (mot[i] < cfg_min) begin
        mot[i] = cfg_min;
      end else if (mot[i] > cfg_max) begin
        mot[i] = cfg_max;
      end
      if (!live) mot[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      motor_front_a  <= mot[0];
      motor_rear_a   <= mot[1];
      motor_front_b  <= mot[2];
      motor_rear_b   <= mot[3];
      disarm_request <= s7_res.armed && s7_res.trip;
      pitch_scaled   <= live ? s7_res.p : '0;
      roll_scaled    <= live ? s7_res.r : '0;
      yaw_scaled     <= live ? s7_res.y : '0;
    end
  end

endmodule
